// ===== rtl/core/joystick_zone_event_generator_top_assert.svh =====
// assertion macros used by the checker file
`ifndef JOYSTICK_ZONE_EVENT_GENERATOR_TOP_ASSERT_SVH
`define JOYSTICK_ZONE_EVENT_GENERATOR_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define JZEG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JZEG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/zeg_pkg.sv =====
package zeg_pkg;

	localparam int unsigned MSG_SLOTS      = 6;
	localparam int unsigned AXIS_SLOTS     = 3;
	localparam int unsigned SLOT_BITS      = $clog2(MSG_SLOTS);
	localparam int unsigned CODE_BITS      = 4;
	localparam int unsigned NUM_CODES      = 15;
	localparam int unsigned THRESH_BITS    = 16;
	localparam int unsigned CFG_DATA_BITS  = 16;
	localparam int unsigned CFG_INDEX_BITS = 3;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned PTR_BITS       = $clog2(QUEUE_DEPTH);

	typedef logic [CODE_BITS-1:0] code_t;

	// zone encoding of the stored axis state
	typedef enum logic [1:0] {
		ZONE_CENTER = 2'd0,
		ZONE_POS    = 2'd1,
		ZONE_NEG    = 2'd2
	} zone_t;

	localparam code_t MSG_AT_CENTER  = 4'd0;
	localparam code_t MSG_AT_RIGHT   = 4'd1;
	localparam code_t MSG_AT_LEFT    = 4'd2;
	localparam code_t MSG_AT_UP      = 4'd3;
	localparam code_t MSG_AT_DOWN    = 4'd4;
	localparam code_t MSG_LEAVE_BASE = 4'd5;
	localparam code_t MSG_ENTER_BASE = 4'd10;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_THRESH_HIGH = 3'd0,
		CFG_THRESH_LOW  = 3'd1,
		CFG_INVERT_H    = 3'd2,
		CFG_INVERT_V    = 3'd3,
		CFG_MSG_ENABLE  = 3'd4
	} cfg_index_t;

	// all messages one input can cause, slots 0..2 horizontal, 3..5 vertical
	typedef struct packed {
		logic [MSG_SLOTS-1:0]  vld;
		code_t [MSG_SLOTS-1:0] code;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_status_t;

	function automatic code_t zone_code(input zone_t zone, input logic axis);
		code_t c;
		unique case (zone)
			ZONE_POS: c = axis ? MSG_AT_UP : MSG_AT_RIGHT;
			ZONE_NEG: c = axis ? MSG_AT_DOWN : MSG_AT_LEFT;
			default:  c = MSG_AT_CENTER;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/joystick_zone_event_generator_top.sv =====
// Joystick zone event generator. Each accepted word carries a horizontal and a
// vertical Q0.SAMPLE_BITS sample; each axis is put into a center, positive or
// negative zone against the thresh_high / thresh_low registers (strictly above
// high wins over strictly below low), optionally inverted per axis. On a zone
// change an axis sends leaving(old), entering(new), then its current zone;
// without a change only the current zone. Horizontal messages come before
// vertical, each is dropped when its message_enable bit is clear, and last
// marks the final message of an input (an input may produce none). Each sample
// word is classified into a bundle of up to six messages, which goes into a
// two-entry queue; the output stage sends one message per cycle from its
// register while msg_stall is low. The front takes the next sample as long as
// the queue has room, even while the output is stalled. Registers are written
// through cfg_we / cfg_index / cfg_data; the user must write them only while
// the block is idle, and the block itself does not enforce this.
module joystick_zone_event_generator_top #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [zeg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [zeg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// sample channel
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [SAMPLE_BITS-1:0]              horiz_sample,
	input  logic [SAMPLE_BITS-1:0]              vert_sample,
	// message channel
	output logic                                msg_valid,
	input  logic                                msg_stall,
	output logic [zeg_pkg::CODE_BITS-1:0]       message_code,
	output logic                                axis,
	output logic                                last
);

	// front to queue
	logic               push;
	zeg_pkg::bundle_t   push_data;
	// queue to back
	zeg_pkg::q_status_t q_status;
	zeg_pkg::bundle_t   pop_data;
	logic               pop;

	// classification, zone state and registers
	zeg_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.horiz_sample (horiz_sample),
		.vert_sample  (vert_sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.q_status     (q_status),
		.push         (push),
		.push_data    (push_data)
	);

	// short queue of message bundles decoupling the two sides
	zeg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_status  (q_status),
		.pop_data  (pop_data)
	);

	// serializer, one message per cycle through the output register while msg_stall is low
	zeg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_data     (pop_data),
		.pop          (pop),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.message_code (message_code),
		.axis         (axis),
		.last         (last)
	);

endmodule

// ===== rtl/core/zeg_front.sv =====
module zeg_front #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [zeg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [zeg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [SAMPLE_BITS-1:0]              horiz_sample,
	input  logic [SAMPLE_BITS-1:0]              vert_sample,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  zeg_pkg::q_status_t                  q_status,
	output logic                                push,
	output zeg_pkg::bundle_t                    push_data
);

	localparam int unsigned AL_BITS = SAMPLE_BITS + zeg_pkg::THRESH_BITS;

	logic [zeg_pkg::THRESH_BITS-1:0] thresh_high_q;
	logic [zeg_pkg::THRESH_BITS-1:0] thresh_low_q;
	logic                            invert_h_q;
	logic                            invert_v_q;
	logic [zeg_pkg::NUM_CODES-1:0]   msg_enable_q;
	zeg_pkg::zone_t                  horiz_zone_q;
	zeg_pkg::zone_t                  vert_zone_q;

	zeg_pkg::zone_t old_z [2];
	zeg_pkg::zone_t new_z [2];
	zeg_pkg::code_t oc [2];
	zeg_pkg::code_t nc [2];
	zeg_pkg::code_t leave_c [2];
	zeg_pkg::code_t enter_c [2];

	// both sides scaled to Q0.(SAMPLE_BITS+16) so the compare is exact
	function automatic zeg_pkg::zone_t classify(
		input logic [SAMPLE_BITS-1:0]              s,
		input logic                                inv,
		input logic [zeg_pkg::THRESH_BITS-1:0]     hi,
		input logic [zeg_pkg::THRESH_BITS-1:0]     lo
	);
		logic [AL_BITS-1:0] s_al;
		logic [AL_BITS-1:0] hi_al;
		logic [AL_BITS-1:0] lo_al;
		zeg_pkg::zone_t     z;
		s_al  = {s, {zeg_pkg::THRESH_BITS{1'b0}}};
		hi_al = {hi, {SAMPLE_BITS{1'b0}}};
		lo_al = {lo, {SAMPLE_BITS{1'b0}}};
		if (s_al > hi_al)
			z = inv ? zeg_pkg::ZONE_NEG : zeg_pkg::ZONE_POS;
		else if (s_al < lo_al)
			z = inv ? zeg_pkg::ZONE_POS : zeg_pkg::ZONE_NEG;
		else
			z = zeg_pkg::ZONE_CENTER;
		return z;
	endfunction

	assign sample_stall = q_status.full;
	assign push         = sample_valid && !q_status.full;

	always_comb begin
		old_z[0] = horiz_zone_q;
		old_z[1] = vert_zone_q;
		new_z[0] = classify(horiz_sample, invert_h_q, thresh_high_q, thresh_low_q);
		new_z[1] = classify(vert_sample, invert_v_q, thresh_high_q, thresh_low_q);
		push_data = '0;
		for (int a = 0; a < 2; a++) begin
			oc[a]      = zeg_pkg::zone_code(old_z[a], a[0]);
			nc[a]      = zeg_pkg::zone_code(new_z[a], a[0]);
			leave_c[a] = zeg_pkg::MSG_LEAVE_BASE + oc[a];
			enter_c[a] = zeg_pkg::MSG_ENTER_BASE + nc[a];
			push_data.code[a*zeg_pkg::AXIS_SLOTS + 0] = leave_c[a];
			push_data.code[a*zeg_pkg::AXIS_SLOTS + 1] = enter_c[a];
			push_data.code[a*zeg_pkg::AXIS_SLOTS + 2] = nc[a];
			push_data.vld[a*zeg_pkg::AXIS_SLOTS + 0] =
				(oc[a] != nc[a]) && msg_enable_q[leave_c[a]];
			push_data.vld[a*zeg_pkg::AXIS_SLOTS + 1] =
				(oc[a] != nc[a]) && msg_enable_q[enter_c[a]];
			push_data.vld[a*zeg_pkg::AXIS_SLOTS + 2] = msg_enable_q[nc[a]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_high_q <= 16'd49152;
			thresh_low_q  <= 16'd16384;
			invert_h_q    <= 1'b0;
			invert_v_q    <= 1'b0;
			msg_enable_q  <= '1;
		end else if (cfg_we) begin
			unique case (zeg_pkg::cfg_index_t'(cfg_index))
				zeg_pkg::CFG_THRESH_HIGH: thresh_high_q <= cfg_data;
				zeg_pkg::CFG_THRESH_LOW:  thresh_low_q  <= cfg_data;
				zeg_pkg::CFG_INVERT_H:    invert_h_q    <= cfg_data[0];
				zeg_pkg::CFG_INVERT_V:    invert_v_q    <= cfg_data[0];
				zeg_pkg::CFG_MSG_ENABLE:  msg_enable_q  <= cfg_data[zeg_pkg::NUM_CODES-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_zone_q <= zeg_pkg::ZONE_CENTER;
			vert_zone_q  <= zeg_pkg::ZONE_CENTER;
		end else if (push) begin
			horiz_zone_q <= new_z[0];
			vert_zone_q  <= new_z[1];
		end
	end

endmodule

// ===== rtl/core/zeg_queue.sv =====
module zeg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  zeg_pkg::bundle_t   push_data,
	input  logic               pop,
	output zeg_pkg::q_status_t q_status,
	output zeg_pkg::bundle_t   pop_data
);

	zeg_pkg::bundle_t              entries_q [zeg_pkg::QUEUE_DEPTH];
	logic [zeg_pkg::PTR_BITS-1:0]  wr_ptr_q;
	logic [zeg_pkg::PTR_BITS-1:0]  rd_ptr_q;
	logic [zeg_pkg::PTR_BITS:0]    count_q;

	assign q_status.full  = (count_q == (zeg_pkg::PTR_BITS+1)'(zeg_pkg::QUEUE_DEPTH));
	assign q_status.avail = (count_q != '0);
	assign pop_data       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/zeg_back.sv =====
module zeg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  zeg_pkg::q_status_t    q_status,
	input  zeg_pkg::bundle_t      pop_data,
	output logic                  pop,
	output logic                  msg_valid,
	input  logic                  msg_stall,
	output zeg_pkg::code_t        message_code,
	output logic                  axis,
	output logic                  last
);

	logic [zeg_pkg::MSG_SLOTS-1:0]  rem_q;
	zeg_pkg::code_t [zeg_pkg::MSG_SLOTS-1:0] codes_q;
	logic                           msg_valid_q;
	zeg_pkg::code_t                 code_q;
	logic                           axis_q;
	logic                           last_q;

	logic [zeg_pkg::MSG_SLOTS-1:0]  lowbit;
	logic [zeg_pkg::MSG_SLOTS-1:0]  rem_after;
	logic [zeg_pkg::SLOT_BITS-1:0]  sel;
	logic                           out_free;
	logic                           emit;

	assign out_free = !msg_valid_q || !msg_stall;
	assign emit     = out_free && (rem_q != '0);
	assign lowbit   = rem_q & (~rem_q + 1'b1);

	always_comb begin
		sel = '0;
		for (int i = 0; i < zeg_pkg::MSG_SLOTS; i++) begin
			if (lowbit[i])
				sel = zeg_pkg::SLOT_BITS'(i);
		end
	end

	assign rem_after = emit ? (rem_q & ~lowbit) : rem_q;
	// next word is fetched once the current one has nothing left to send
	assign pop       = q_status.avail && (rem_after == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			msg_valid_q <= 1'b0;
		end else begin
			rem_q <= pop ? pop_data.vld : rem_after;
			if (emit)
				msg_valid_q <= 1'b1;
			else if (out_free)
				msg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			codes_q <= pop_data.code;
		if (emit) begin
			code_q <= codes_q[sel];
			axis_q <= (sel >= zeg_pkg::SLOT_BITS'(zeg_pkg::AXIS_SLOTS));
			last_q <= (rem_after == '0);
		end
	end

	assign msg_valid    = msg_valid_q;
	assign message_code = code_q;
	assign axis         = axis_q;
	assign last         = last_q;

endmodule

// ===== rtl/core/zeg_checker.sv =====
`include "joystick_zone_event_generator_top_assert.svh"

module zeg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          msg_valid,
	input logic                          msg_stall,
	input logic [zeg_pkg::CODE_BITS-1:0] message_code,
	input logic                          axis,
	input logic                          last
);

	localparam zeg_pkg::code_t MAX_CODE    = zeg_pkg::code_t'(zeg_pkg::NUM_CODES - 1);
	localparam zeg_pkg::code_t LEAVE_RIGHT = zeg_pkg::MSG_LEAVE_BASE + zeg_pkg::MSG_AT_RIGHT;
	localparam zeg_pkg::code_t LEAVE_LEFT  = zeg_pkg::MSG_LEAVE_BASE + zeg_pkg::MSG_AT_LEFT;
	localparam zeg_pkg::code_t LEAVE_UP    = zeg_pkg::MSG_LEAVE_BASE + zeg_pkg::MSG_AT_UP;
	localparam zeg_pkg::code_t LEAVE_DOWN  = zeg_pkg::MSG_LEAVE_BASE + zeg_pkg::MSG_AT_DOWN;
	localparam zeg_pkg::code_t ENTER_RIGHT = zeg_pkg::MSG_ENTER_BASE + zeg_pkg::MSG_AT_RIGHT;
	localparam zeg_pkg::code_t ENTER_LEFT  = zeg_pkg::MSG_ENTER_BASE + zeg_pkg::MSG_AT_LEFT;
	localparam zeg_pkg::code_t ENTER_UP    = zeg_pkg::MSG_ENTER_BASE + zeg_pkg::MSG_AT_UP;
	localparam zeg_pkg::code_t ENTER_DOWN  = zeg_pkg::MSG_ENTER_BASE + zeg_pkg::MSG_AT_DOWN;

	// which axis a message code belongs to, center codes belong to neither
	logic horiz_msg;
	logic vert_msg;

	always_comb begin
		horiz_msg = 1'b0;
		vert_msg  = 1'b0;
		unique case (message_code) inside
			zeg_pkg::MSG_AT_RIGHT, zeg_pkg::MSG_AT_LEFT, LEAVE_RIGHT, LEAVE_LEFT,
			ENTER_RIGHT, ENTER_LEFT: horiz_msg = 1'b1;
			zeg_pkg::MSG_AT_UP, zeg_pkg::MSG_AT_DOWN, LEAVE_UP, LEAVE_DOWN,
			ENTER_UP, ENTER_DOWN:    vert_msg  = 1'b1;
			default: ;
		endcase
	end

	`JZEG_ASSERT_NEXT(a_valid_holds, clk, arst_n, msg_valid && msg_stall, msg_valid, "valid dropped while stalled")
	`JZEG_ASSERT_SAME(a_code_range, clk, arst_n, msg_valid, message_code <= MAX_CODE, "message code out of range")
	`JZEG_ASSERT_SAME(a_horiz_axis, clk, arst_n, msg_valid && horiz_msg, !axis, "left/right message on vertical axis")
	`JZEG_ASSERT_SAME(a_vert_axis, clk, arst_n, msg_valid && vert_msg, axis, "up/down message on horizontal axis")
	`JZEG_ASSERT_NEXT(a_burst_continues, clk, arst_n, msg_valid && !msg_stall && !last, msg_valid, "gap inside the messages of one input")

endmodule

bind joystick_zone_event_generator_top zeg_checker u_zeg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_valid    (msg_valid),
	.msg_stall    (msg_stall),
	.message_code (message_code),
	.axis         (axis),
	.last         (last)
);
